FILE: rtl/core/hbs_pkg.sv
// shared types and constants of the height map box smoother
package hbs_pkg;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // fixed field widths
  localparam int SAMPLE_W = 8;
  localparam int DIM_W    = 11;
  localparam int SCALE_W  = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 2;
  localparam int SUM_W    = 12;
  localparam int DIV_W    = 12;
  localparam int Q_W      = 16;
  localparam int PROD_W   = SUM_W + SCALE_W;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 2'd2;

  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  localparam logic [DIM_W-1:0]   DIM_RESET   = 11'd1024;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SHIFT,
    ST_SUM,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_OUT
  } hbs_state_t;

  typedef struct packed {
    logic accept;
    logic mem_rd;
    logic shift;
    logic sum;
    logic mul;
    logic div_start;
    logic out_load;
  } hbs_cmd_t;

  typedef struct packed {
    logic frame_done;
    logic in_is_flush;
    logic win_ready;
    logic flush_mode;
    logic div_done;
    logic div_busy;
    logic slot_free;
  } hbs_stat_t;

endpackage

FILE: rtl/core/heightmap_box_smoother_top.sv
// top level of the height map 3x3 box smoother
// Takes 8-bit height samples in raster order and returns, per pixel, the mean of the
// in-frame part of its 3x3 neighborhood scaled by height_scale/255 as unsigned Q8.8,
// truncated. Results lag the input by one row plus one pixel; once the frame's samples
// are in, each flush request (or any further request) drains one pending result, and
// out_frame_last marks the frame's final one, after which the next sample opens a new
// frame. Requests are handled one at a time; a request that yields a result runs the
// 16-step divider, which divides by 255 times the window count, and a one-row frame
// may need an extra empty shift first. The line store is one single-port memory read and
// written in separate cycles. A finished result waits in the output register while
// the next request is taken. Writing image_width or image_height restarts the frame.
module heightmap_box_smoother_top #(
  parameter int MAX_WIDTH  = hbs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hbs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [hbs_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hbs_pkg::Q_W-1:0]       out_smoothed_height,
  output logic                          out_frame_last,
  input  logic                          cfg_wr_en,
  input  logic [hbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hbs_pkg::CFG_W-1:0]     cfg_wdata
);
  import hbs_pkg::*;

  hbs_cmd_t  cmd;
  hbs_stat_t stat;

  hbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hbs_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_opcode           (in_opcode),
    .in_sample           (in_sample),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_smoothed_height (out_smoothed_height),
    .out_frame_last      (out_frame_last),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  // result register is only loaded when it is free or being emptied
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> stat.slot_free)
    else $error("result loaded over a pending one");

  // datapath steps never overlap
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.accept, cmd.mem_rd, cmd.shift, cmd.sum, cmd.mul, cmd.div_start,
              cmd.out_load}))
    else $error("overlapping datapath commands");

  // no new request while the divider still runs
  a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !stat.div_busy)
    else $error("request taken during division");

  // a division start is followed by a running divider
  a_div_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |=> stat.div_busy)
    else $error("divider did not start");

endmodule

FILE: rtl/core/hbs_divider.sv
// restoring divider, one quotient bit per cycle
module hbs_divider (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [hbs_pkg::PROD_W-1:0] dividend,
  input  logic [hbs_pkg::DIV_W-1:0]  divisor,
  output logic                       busy,
  output logic                       done,
  output logic [hbs_pkg::Q_W-1:0]    quotient
);
  import hbs_pkg::*;

  localparam int CNT_W = $clog2(Q_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DIV_W-1:0] rem_r;
  logic [DIV_W-1:0] rem_nxt;
  logic [DIV_W-1:0] dv_r;
  logic [Q_W-1:0]   q_r;
  logic [DIV_W:0]   trial;
  logic             ge;

  // quotient always fits in Q_W bits, so the upper dividend bits start below the divisor
  assign trial   = {rem_r, q_r[Q_W-1]};
  assign ge      = trial >= {1'b0, dv_r};
  assign rem_nxt = ge ? DIV_W'(trial - {1'b0, dv_r}) : trial[DIV_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(Q_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= dividend[PROD_W-1:Q_W];
      q_r   <= dividend[Q_W-1:0];
      dv_r  <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[Q_W-2:0], ge};
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: rtl/core/hbs_datapath.sv
// line store, window, configuration and position counters, sum, scale, divider and output register
module hbs_datapath #(
  parameter int MAX_WIDTH  = hbs_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = hbs_pkg::MAX_HEIGHT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  hbs_pkg::hbs_cmd_t             cmd,
  output hbs_pkg::hbs_stat_t            stat,
  input  logic                          in_opcode,
  input  logic [hbs_pkg::SAMPLE_W-1:0]  in_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [hbs_pkg::Q_W-1:0]       out_smoothed_height,
  output logic                          out_frame_last,
  input  logic                          cfg_wr_en,
  input  logic [hbs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hbs_pkg::CFG_W-1:0]     cfg_wdata
);
  import hbs_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int WW  = $clog2(MAX_WIDTH + 1);
  localparam int ORW = $clog2(MAX_HEIGHT);
  localparam int HW  = $clog2(MAX_HEIGHT + 1);
  localparam int IRW = HW + 1;

  function automatic logic [WW-1:0] clamp_w(input logic [DIM_W-1:0] v);
    if (v == '0) return WW'(1);
    if (32'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
    return WW'(v);
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [DIM_W-1:0] v);
    if (v == '0) return HW'(1);
    if (32'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
    return HW'(v);
  endfunction

  logic [WW-1:0]      w_r;
  logic [HW-1:0]      h_r;
  logic [SCALE_W-1:0] scale_r;

  logic [CW-1:0]  in_col_r;
  logic [IRW-1:0] in_row_r;
  logic [CW-1:0]  out_col_r;
  logic [ORW-1:0] out_row_r;

  logic [CW-1:0]  in_col_nxt;
  logic [IRW-1:0] in_row_nxt;
  logic [CW-1:0]  out_col_nxt;
  logic [ORW-1:0] out_row_nxt;

  logic [SAMPLE_W-1:0]   val_r;
  logic                  flush_r;
  logic [2*SAMPLE_W-1:0] line_mem [MAX_WIDTH];
  logic [2*SAMPLE_W-1:0] rd_r;
  logic [SAMPLE_W-1:0]   win_r [9];

  logic [SUM_W-1:0]  sum_r;
  logic [SUM_W-1:0]  sum_nxt;
  logic [DIV_W-1:0]  divisor_r;
  logic [DIV_W-1:0]  divisor_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [Q_W-1:0]    quotient;
  logic              div_busy;
  logic              div_done;

  logic           out_valid_r;
  logic [Q_W-1:0] out_data_r;
  logic           out_last_r;

  logic [2:0] row_ok;
  logic [2:0] col_ok;
  logic [1:0] rows;
  logic [1:0] cols;
  logic [3:0] count;
  logic       frame_last;
  logic       frame_done;
  logic       slot_free;
  logic [WW:0] in_col_inc;
  logic [WW:0] out_col_inc;

  assign frame_done = in_row_r >= IRW'(h_r);
  assign slot_free  = !out_valid_r || out_ready;

  // window neighborhood masks for the pending output pixel
  assign row_ok[0] = out_row_r != '0;
  assign row_ok[1] = 1'b1;
  assign row_ok[2] = (HW'(out_row_r) + 1'b1) < h_r;
  assign col_ok[0] = out_col_r != '0;
  assign col_ok[1] = 1'b1;
  assign col_ok[2] = (WW'(out_col_r) + 1'b1) < w_r;
  assign frame_last = !row_ok[2] && !col_ok[2];

  assign rows  = 2'd1 + 2'(row_ok[0]) + 2'(row_ok[2]);
  assign cols  = 2'd1 + 2'(col_ok[0]) + 2'(col_ok[2]);
  assign count = rows * cols;
  // 255 * count
  assign divisor_nxt = {count, 8'd0} - DIV_W'(count);

  always_comb begin
    sum_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        if (col_ok[c] && row_ok[r]) begin
          sum_nxt = sum_nxt + SUM_W'(win_r[c*3 + r]);
        end
      end
    end
  end

  assign in_col_inc  = (WW+1)'(in_col_r) + 1'b1;
  assign out_col_inc = (WW+1)'(out_col_r) + 1'b1;

  always_comb begin
    in_col_nxt = in_col_r;
    in_row_nxt = in_row_r;
    if (in_col_inc >= (WW+1)'(w_r)) begin
      in_col_nxt = '0;
      in_row_nxt = in_row_r + 1'b1;
    end else begin
      in_col_nxt = CW'(in_col_inc);
    end
  end

  always_comb begin
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    if (out_col_inc >= (WW+1)'(w_r)) begin
      out_col_nxt = '0;
      out_row_nxt = out_row_r + 1'b1;
    end else begin
      out_col_nxt = CW'(out_col_inc);
    end
  end

  // configuration and position counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= clamp_w(DIM_RESET);
      h_r       <= clamp_h(DIM_RESET);
      scale_r   <= SCALE_RESET;
      in_col_r  <= '0;
      in_row_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          w_r       <= clamp_w(cfg_wdata[DIM_W-1:0]);
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          h_r       <= clamp_h(cfg_wdata[DIM_W-1:0]);
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
        end
        REG_HEIGHT_SCALE: begin
          scale_r <= cfg_wdata[SCALE_W-1:0];
        end
        default: begin
        end
      endcase
    end else begin
      if (cmd.shift) begin
        in_col_r <= in_col_nxt;
        in_row_r <= in_row_nxt;
      end
      if (cmd.out_load) begin
        if (frame_last) begin
          in_col_r  <= '0;
          in_row_r  <= '0;
          out_col_r <= '0;
          out_row_r <= '0;
        end else begin
          out_col_r <= out_col_nxt;
          out_row_r <= out_row_nxt;
        end
      end
    end
  end

  // request capture; past the end of the frame every request shifts in zero
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      val_r   <= frame_done ? '0 : in_sample;
      flush_r <= frame_done;
    end
  end

  // line store: upper byte is the upper line, lower byte the middle line
  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      rd_r <= line_mem[in_col_r];
    end
    if (cmd.shift) begin
      line_mem[in_col_r] <= {rd_r[SAMPLE_W-1:0], val_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (cmd.shift) begin
      for (int i = 0; i < 6; i++) begin
        win_r[i] <= win_r[i+3];
      end
      win_r[6] <= rd_r[2*SAMPLE_W-1:SAMPLE_W];
      win_r[7] <= rd_r[SAMPLE_W-1:0];
      win_r[8] <= val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      sum_r     <= sum_nxt;
      divisor_r <= divisor_nxt;
    end
    if (cmd.mul) begin
      prod_r <= sum_r * scale_r;
    end
  end

  hbs_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (prod_r),
    .divisor  (divisor_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data_r <= quotient;
      out_last_r <= frame_last;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_smoothed_height = out_data_r;
  assign out_frame_last      = out_last_r;

  assign stat.frame_done  = frame_done;
  assign stat.in_is_flush = in_opcode == OP_FLUSH;
  assign stat.win_ready   = (in_row_r >= IRW'(2)) || (in_row_r == IRW'(1) && in_col_r != '0);
  assign stat.flush_mode  = flush_r;
  assign stat.div_done    = div_done;
  assign stat.div_busy    = div_busy;
  assign stat.slot_free   = slot_free;

endmodule

FILE: rtl/core/hbs_ctrl.sv
// sequencing state machine of the smoother
module hbs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  hbs_pkg::hbs_stat_t stat,
  output hbs_pkg::hbs_cmd_t  cmd
);
  import hbs_pkg::*;

  hbs_state_t state_r;
  hbs_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // a flush inside the frame is dropped
          if (stat.frame_done || !stat.in_is_flush) begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        state_nxt = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (stat.win_ready) begin
          state_nxt = ST_SUM;
        end else if (stat.flush_mode) begin
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SUM: begin
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        state_nxt = ST_START;
      end
      ST_START: begin
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (stat.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
      end
      ST_SHIFT: begin
        cmd.shift = 1'b1;
      end
      ST_SUM: begin
        cmd.sum = 1'b1;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
      end
      ST_OUT: begin
        cmd.out_load = stat.slot_free;
      end
      default: begin
      end
    endcase
  end

endmodule
